FILE: src/fcfla_pkg.sv
// shared types and constants of the fixed chunk free list allocator
`timescale 1ns / 1ps

package fcfla_pkg;

    // field widths
    localparam int CMD_W        = 2;
    localparam int INDEX_W      = 10;
    localparam int COUNT_W      = 11;
    localparam int STATUS_W     = 2;
    localparam int ADDR_W       = 48;
    localparam int CHUNK_SIZE_W = 31;
    localparam int POOL_SIZE_W  = 41;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 48;

    // pool geometry; the region alignment is a power of two
    localparam int MAX_CHUNKS_DEF = 1024;
    localparam longint unsigned REGION_ALIGN = 64'd2097152;
    // rounded region plus one chunk step still fits
    localparam int REGION_W = POOL_SIZE_W + 1;

    // register reset values
    localparam logic [CHUNK_SIZE_W-1:0] CHUNK_SIZE_RST = 31'd4096;
    localparam logic [POOL_SIZE_W-1:0]  POOL_SIZE_RST  = 41'd2097152;
    localparam logic [ADDR_W-1:0]       BASE_ADDR_RST  = '0;
    localparam logic [ADDR_W-1:0]       BASE_IOVA_RST  = '0;

    // item commands, code 3 is unused and does nothing
    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHUNK_SIZE = 2'd0,
        CFG_POOL_SIZE  = 2'd1,
        CFG_BASE_ADDR  = 2'd2,
        CFG_BASE_IOVA  = 2'd3
    } cfg_reg_t;

    // input item
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] chunk_index;
    } in_t;

    // result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted_index;
        logic [ADDR_W-1:0]   chunk_addr;
        logic [ADDR_W-1:0]   chunk_iova;
        logic [COUNT_W-1:0]  free_count;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    init_start;
        logic    init_step;
        logic    init_end;
        logic    pop;
        logic    mul;
        logic    push;
        logic    load;
        status_t out_status;
        logic    out_grant;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             empty;
        logic             idx_bad;
        logic             full;
        logic             walk_done;
        logic             out_free;
    } dp_sts_t;

endpackage

FILE: src/fcfla_ctrl.sv
// controller state machine of the free list allocator
`timescale 1ns / 1ps

module fcfla_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fcfla_pkg::dp_sts_t    sts,
    output fcfla_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INIT_WALK,
        S_POP_MUL,
        S_RESULT
    } state_t;

    state_t              state_reg, state_next;
    fcfla_pkg::status_t  status_reg, status_next;
    logic                grant_reg, grant_next;

    assign s_ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        grant_next     = grant_reg;
        cmd            = '0;
        cmd.out_status = status_reg;
        cmd.out_grant  = grant_reg;
        cmd.accept     = s_valid && s_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next = fcfla_pkg::ST_OK;
                grant_next  = 1'b0;
                state_next  = S_RESULT;
                unique case (sts.command)
                    fcfla_pkg::CMD_INIT: begin
                        cmd.init_start = 1'b1;
                        state_next     = S_INIT_WALK;
                    end
                    fcfla_pkg::CMD_ALLOC: begin
                        if (sts.empty) begin
                            status_next = fcfla_pkg::ST_EMPTY;
                        end else begin
                            cmd.pop    = 1'b1;
                            grant_next = 1'b1;
                            state_next = S_POP_MUL;
                        end
                    end
                    fcfla_pkg::CMD_FREE: begin
                        priority if (sts.idx_bad) begin
                            status_next = fcfla_pkg::ST_BAD_INDEX;
                        end else if (sts.full) begin
                            status_next = fcfla_pkg::ST_FULL;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end
                    default: begin
                        // unused command: plain ok result
                    end
                endcase
            end
            S_INIT_WALK: begin
                if (sts.walk_done) begin
                    cmd.init_end = 1'b1;
                    state_next   = S_RESULT;
                end else begin
                    cmd.init_step = 1'b1;
                end
            end
            S_POP_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result code registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= fcfla_pkg::ST_OK;
            grant_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            grant_reg  <= grant_next;
        end
    end

endmodule

FILE: src/fcfla_dp.sv
// datapath: config registers, free stack memory, init walk, address math
`timescale 1ns / 1ps

module fcfla_dp #(
    parameter int MAX_CHUNKS = fcfla_pkg::MAX_CHUNKS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  fcfla_pkg::in_t                        s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output fcfla_pkg::out_t                       m_data,
    input  logic                                  cfg_wr_en,
    input  logic [fcfla_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fcfla_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  fcfla_pkg::ctrl_cmd_t                  cmd,
    output fcfla_pkg::dp_sts_t                    sts
);

    localparam int IDX_W   = $clog2(MAX_CHUNKS);
    localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
    localparam int IN_W    = fcfla_pkg::INDEX_W;
    localparam int OCNT_W  = fcfla_pkg::COUNT_W;
    localparam int CMP_W   = (CNT_W > IN_W) ? CNT_W : IN_W;
    localparam int CS_W    = fcfla_pkg::CHUNK_SIZE_W;
    localparam int POOL_W  = fcfla_pkg::POOL_SIZE_W;
    localparam int ADR_W   = fcfla_pkg::ADDR_W;
    localparam int RGN_W   = fcfla_pkg::REGION_W;
    localparam int PROD_W  = IDX_W + CS_W;
    localparam logic [RGN_W-1:0] AlignMask = RGN_W'(fcfla_pkg::REGION_ALIGN - 64'd1);
    localparam logic [CNT_W-1:0] MaxCount  = CNT_W'(MAX_CHUNKS);

    // configuration registers
    logic [CS_W-1:0]   chunk_size_reg;
    logic [POOL_W-1:0] pool_size_reg;
    logic [ADR_W-1:0]  base_addr_reg;
    logic [ADR_W-1:0]  base_iova_reg;

    // stack state
    logic [IDX_W-1:0]  stack_mem [MAX_CHUNKS];
    logic [CNT_W-1:0]  top_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [IDX_W-1:0]  rd_data_reg;

    // init walk
    logic [CNT_W-1:0]  walk_reg;
    logic [RGN_W-1:0]  acc_reg;
    logic [RGN_W-1:0]  region_reg;

    // item and pop pipeline
    fcfla_pkg::in_t    item_reg;
    logic [IDX_W-1:0]  grant_reg;
    logic [PROD_W-1:0] prod_reg;

    // result register
    logic              out_valid_reg;
    fcfla_pkg::out_t   out_reg;

    logic [CS_W-1:0]   cs_eff;
    logic [RGN_W-1:0]  region_round;
    logic [CNT_W-1:0]  top_dec;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_wdata;
    logic [ADR_W-1:0]  offset;

    // zero chunk size counts as one byte
    assign cs_eff = (chunk_size_reg == '0) ? CS_W'(1) : chunk_size_reg;

    // pool size rounded up to the region alignment
    assign region_round = (RGN_W'(pool_size_reg) + AlignMask) & ~AlignMask;

    assign top_dec = top_reg - CNT_W'(1);
    assign offset  = ADR_W'(prod_reg);

    // status toward the controller
    assign sts.command   = item_reg.command;
    assign sts.empty     = (top_reg == '0);
    assign sts.idx_bad   = CMP_W'(item_reg.chunk_index) >= CMP_W'(total_reg);
    assign sts.full      = (top_reg >= total_reg);
    assign sts.walk_done = (acc_reg >= region_reg) || (walk_reg == MaxCount);
    assign sts.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= fcfla_pkg::CHUNK_SIZE_RST;
            pool_size_reg  <= fcfla_pkg::POOL_SIZE_RST;
            base_addr_reg  <= fcfla_pkg::BASE_ADDR_RST;
            base_iova_reg  <= fcfla_pkg::BASE_IOVA_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fcfla_pkg::CFG_CHUNK_SIZE: chunk_size_reg <= cfg_wdata[CS_W-1:0];
                fcfla_pkg::CFG_POOL_SIZE:  pool_size_reg  <= cfg_wdata[POOL_W-1:0];
                fcfla_pkg::CFG_BASE_ADDR:  base_addr_reg  <= cfg_wdata[ADR_W-1:0];
                fcfla_pkg::CFG_BASE_IOVA:  base_iova_reg  <= cfg_wdata[ADR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // memory write port: init walk or push
    always_comb begin
        mem_we    = cmd.init_step || cmd.push;
        mem_waddr = cmd.init_step ? walk_reg[IDX_W-1:0] : top_reg[IDX_W-1:0];
        mem_wdata = cmd.init_step ? walk_reg[IDX_W-1:0] : IDX_W'(item_reg.chunk_index);
    end

    // free stack memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.pop) begin
            rd_data_reg <= stack_mem[top_dec[IDX_W-1:0]];
        end
    end

    // stack pointer, chunk count and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            priority if (cmd.init_end) begin
                top_reg   <= walk_reg;
                total_reg <= walk_reg;
            end else if (cmd.pop) begin
                top_reg <= top_dec;
            end else if (cmd.push) begin
                top_reg <= top_reg + CNT_W'(1);
            end
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture, init walk, offset multiply and result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.init_start) begin
            walk_reg   <= '0;
            acc_reg    <= '0;
            region_reg <= region_round;
        end else if (cmd.init_step) begin
            walk_reg <= walk_reg + CNT_W'(1);
            acc_reg  <= acc_reg + RGN_W'(cs_eff);
        end
        if (cmd.mul) begin
            grant_reg <= rd_data_reg;
            prod_reg  <= PROD_W'(rd_data_reg) * PROD_W'(cs_eff);
        end
        if (cmd.load) begin
            out_reg.status     <= cmd.out_status;
            out_reg.free_count <= OCNT_W'(top_reg);
            if (cmd.out_grant) begin
                out_reg.granted_index <= IN_W'(grant_reg);
                out_reg.chunk_addr    <= base_addr_reg + offset;
                out_reg.chunk_iova    <= base_iova_reg + offset;
            end else begin
                out_reg.granted_index <= '0;
                out_reg.chunk_addr    <= '0;
                out_reg.chunk_iova    <= '0;
            end
        end
    end

endmodule

FILE: src/fixed_chunk_free_list_allocator.sv
// top level of the fixed chunk free list allocator
//
//   channel  ports                        direction  carries
//   s_       s_valid s_ready s_data       in         command item (init, alloc, free)
//   m_       m_valid m_ready m_data       out        result item, one per command
//   cfg_     cfg_wr_en cfg_index cfg_wdata in        register writes, no wait
//
// free, empty alloc and unused command: exec and result states between accept and next accept
// alloc: adds the stack memory read, then the index times chunk size multiply
// init: walks the chunks after the exec state; the walk writes one stack entry per cycle
// through the single memory write port and steps the region compare
// reset is synchronous, active low; the stack memory is not cleared
// a stalled result holds in the output register while the next item is taken
`timescale 1ns / 1ps

module fixed_chunk_free_list_allocator #(
    parameter int MAX_CHUNKS = fcfla_pkg::MAX_CHUNKS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fcfla_pkg::in_t                    s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fcfla_pkg::out_t                   m_data,
    input  logic                              cfg_wr_en,
    input  logic [fcfla_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fcfla_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    fcfla_pkg::ctrl_cmd_t cmd;
    fcfla_pkg::dp_sts_t   sts;

    // sequencing
    fcfla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage and arithmetic
    fcfla_dp #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: src/fcfla_checker.sv
// port level checks for the free list allocator, bound to the top level
`timescale 1ns / 1ps

module fcfla_port_checks (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input fcfla_pkg::out_t                   m_data
);

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready stayed high after an accepted item");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // a new result only appears right after the block was busy
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while the block was idle");

    // empty pool reports zero free entries
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == fcfla_pkg::ST_EMPTY) |-> (m_data.free_count == '0))
        else $error("empty status with free entries left");

    // only a granted alloc carries an index and addresses
    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != fcfla_pkg::ST_OK)
        |-> (m_data.granted_index == '0 && m_data.chunk_addr == '0
             && m_data.chunk_iova == '0))
        else $error("failed command returned a chunk");

endmodule

bind fixed_chunk_free_list_allocator fcfla_port_checks u_fcfla_port_checks (.*);
